FILE: design/sqt_pkg.sv
// Shared types, character codes and helpers for the shell quote tokenizer.
`timescale 1ns / 1ps

package sqt_pkg;

    localparam int BUNDLE_ITEMS = 3;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_DOLLAR    = 8'h24;
    localparam logic [7:0] CH_BACKTICK  = 8'h60;

    localparam logic KIND_CHAR     = 1'b0;
    localparam logic KIND_WORD_END = 1'b1;

    typedef enum logic [1:0] {
        QM_PLAIN  = 2'd0,
        QM_SINGLE = 2'd1,
        QM_DOUBLE = 2'd2
    } quote_mode_t;

    typedef struct packed {
        logic [7:0] in_char;
        logic       end_of_text;
    } item_t;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] word_char;
        logic       run_last;
    } result_t;

    // All results caused by one input item, oldest in slot 0.
    typedef struct packed {
        logic [1:0]                   cnt;
        result_t [BUNDLE_ITEMS-1:0]   items;
    } bundle_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c >= 8'h09 && c <= 8'h0D) || c == 8'h20 || c == 8'h85 || c == 8'hA0;
    endfunction

    function automatic logic dq_escapable(input logic [7:0] c);
        return c == CH_DQUOTE || c == CH_BACKSLASH || c == CH_DOLLAR || c == CH_BACKTICK;
    endfunction

    function automatic result_t make_char(input logic [7:0] c);
        result_t r;
        r.result_kind = KIND_CHAR;
        r.word_char   = c;
        r.run_last    = 1'b0;
        return r;
    endfunction

    function automatic result_t make_word_end();
        result_t r;
        r.result_kind = KIND_WORD_END;
        r.word_char   = 8'h00;
        r.run_last    = 1'b0;
        return r;
    endfunction

endpackage

FILE: design/sqt_front.sv
// Front end: quoting state and classification of each character into a result bundle.
`timescale 1ns / 1ps

module sqt_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  sqt_pkg::item_t   item,
    output logic             bundle_push,
    output sqt_pkg::bundle_t bundle
);
    import sqt_pkg::*;

    quote_mode_t mode_reg, mode_next;
    logic        esc_reg, esc_next;
    logic        open_reg, open_next;
    logic        open_pre;
    logic [7:0]  c;
    logic        eot;

    assign c   = item.in_char;
    assign eot = item.end_of_text;

    // Next state
    always_comb
    begin
        mode_next = mode_reg;
        esc_next  = esc_reg;
        open_pre  = open_reg;
        unique case (mode_reg)
            QM_SINGLE:
            begin
                if (c == CH_SQUOTE)
                    mode_next = QM_PLAIN;
            end
            QM_DOUBLE:
            begin
                if (esc_reg)
                    esc_next = 1'b0;
                else if (c == CH_BACKSLASH)
                    esc_next = !eot;
                else if (c == CH_DQUOTE)
                    mode_next = QM_PLAIN;
            end
            default:
            begin
                if (esc_reg)
                begin
                    esc_next = 1'b0;
                    open_pre = 1'b1;
                end
                else if (c == CH_SQUOTE)
                begin
                    mode_next = QM_SINGLE;
                    open_pre  = 1'b1;
                end
                else if (c == CH_DQUOTE)
                begin
                    mode_next = QM_DOUBLE;
                    open_pre  = 1'b1;
                end
                else if (c == CH_BACKSLASH)
                begin
                    open_pre = 1'b1;
                    esc_next = !eot;
                end
                else if (is_space(c))
                    open_pre = 1'b0;
                else
                    open_pre = 1'b1;
            end
        endcase
        open_next = open_pre;
        // End of text clears everything
        if (eot)
        begin
            mode_next = QM_PLAIN;
            esc_next  = 1'b0;
            open_next = 1'b0;
        end
    end

    // Outputs
    always_comb
    begin
        logic [1:0] n;
        n = 2'd0;
        bundle.items = '0;
        unique case (mode_reg)
            QM_SINGLE:
            begin
                if (c != CH_SQUOTE)
                begin
                    bundle.items[n] = make_char(c);
                    n = n + 2'd1;
                end
            end
            QM_DOUBLE:
            begin
                if (esc_reg)
                begin
                    if (!dq_escapable(c))
                    begin
                        bundle.items[n] = make_char(CH_BACKSLASH);
                        n = n + 2'd1;
                    end
                    bundle.items[n] = make_char(c);
                    n = n + 2'd1;
                end
                else if (c == CH_BACKSLASH)
                begin
                    if (eot)
                    begin
                        bundle.items[n] = make_char(c);
                        n = n + 2'd1;
                    end
                end
                else if (c != CH_DQUOTE)
                begin
                    bundle.items[n] = make_char(c);
                    n = n + 2'd1;
                end
            end
            default:
            begin
                if (esc_reg)
                begin
                    bundle.items[n] = make_char(c);
                    n = n + 2'd1;
                end
                else if (c == CH_SQUOTE || c == CH_DQUOTE)
                begin
                    n = n;
                end
                else if (c == CH_BACKSLASH)
                begin
                    if (eot)
                    begin
                        bundle.items[n] = make_char(c);
                        n = n + 2'd1;
                    end
                end
                else if (is_space(c))
                begin
                    if (open_reg)
                    begin
                        bundle.items[n] = make_word_end();
                        n = n + 2'd1;
                    end
                end
                else
                begin
                    bundle.items[n] = make_char(c);
                    n = n + 2'd1;
                end
            end
        endcase
        if (eot && open_pre)
        begin
            bundle.items[n] = make_word_end();
            n = n + 2'd1;
        end
        for (int i = 0; i < BUNDLE_ITEMS; i++)
            bundle.items[i].run_last = (n == 2'(i + 1));
        bundle.cnt  = n;
        bundle_push = accept && (n != 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= QM_PLAIN;
            esc_reg  <= 1'b0;
            open_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            esc_reg  <= esc_next;
            open_reg <= open_next;
        end
    end

`ifndef SYNTHESIS
    a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && eot |=> mode_reg == QM_PLAIN && !esc_reg && !open_reg)
        else $error("state not cleared after end of text");

    a_no_esc_single: assert property (@(posedge clk) disable iff (!rst_n)
        !(esc_reg && mode_reg == QM_SINGLE))
        else $error("escape pending inside single quotes");

    a_one_last: assert property (@(posedge clk) disable iff (!rst_n)
        bundle_push |-> $countones({bundle.items[0].run_last, bundle.items[1].run_last,
                                    bundle.items[2].run_last}) == 1)
        else $error("bundle must mark exactly one last result");

    a_quoted_open: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != QM_PLAIN |-> open_reg)
        else $error("quote open without an open word");
`endif

endmodule

FILE: design/sqt_queue.sv
// Short bundle queue between the front end and the serializer.
`timescale 1ns / 1ps

module sqt_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  sqt_pkg::bundle_t wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic             rd_valid,
    output sqt_pkg::bundle_t rd_data
);
    import sqt_pkg::*;

    bundle_t              mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QUEUE_AW:0]    count_reg, count_next;
    logic                 do_wr;
    logic                 do_rd;

    assign full     = count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = mem[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[QUEUE_AW-1:0])
        else $error("queue pointers disagree with count");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        do_wr && !do_rd |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a write");
`endif

endmodule

FILE: design/sqt_back.sv
// Back end: serializes bundles into single results held in the output register.
`timescale 1ns / 1ps

module sqt_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  sqt_pkg::bundle_t head,
    output logic             head_pop,
    output logic             empty,
    input  logic             pop,
    output sqt_pkg::result_t result
);
    import sqt_pkg::*;

    logic [1:0] idx_reg;
    logic       out_valid_reg;
    result_t    out_data_reg;
    logic       load;
    logic       last;
    result_t    cur;

    assign cur      = head.items[idx_reg];
    assign last     = idx_reg == (head.cnt - 2'd1);
    assign load     = head_valid && (!out_valid_reg || pop);
    assign head_pop = load && last;
    assign empty    = !out_valid_reg;
    assign result   = out_data_reg;

    always_ff @(posedge clk)
    begin
        if (load)
            out_data_reg <= cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                // advance within the bundle, or drop it after its last result
                idx_reg <= last ? 2'd0 : idx_reg + 2'd1;
            end
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (cur.run_last == last))
        else $error("run_last does not match bundle position");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> idx_reg < head.cnt)
        else $error("serializer index past bundle end");

    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> idx_reg == 2'd0)
        else $error("serializer index left mid bundle");
`endif

endmodule

FILE: design/shell_quote_tokenizer.sv
// Top level of the shell quote tokenizer: front end, bundle queue and serializer.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------
//  input    | push / full        | item   (in_char, end_of_text)
//  result   | empty / pop        | result (result_kind, word_char, run_last)
//
// One character is accepted per cycle while full is low; it is classified in that
// cycle and its 1 to 3 results, if any, are queued as one bundle. Results leave
// one per cycle from the output register while pop is held. The first result
// passes through the bundle queue and then the output register. full rises when
// the four-entry bundle queue fills, that is when the result side falls behind.
// Reset clears quoting state, queue and output valid flag at once.
`timescale 1ns / 1ps

module shell_quote_tokenizer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  sqt_pkg::item_t   item,
    output logic             empty,
    input  logic             pop,
    output sqt_pkg::result_t result
);
    import sqt_pkg::*;

    logic    accept;
    logic    bundle_push;
    bundle_t bundle;
    logic    head_valid;
    bundle_t head;
    logic    head_pop;

    assign accept = push && !full;

    sqt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (item),
        .bundle_push (bundle_push),
        .bundle      (bundle)
    );

    sqt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (bundle_push),
        .wr_data  (bundle),
        .full     (full),
        .rd_en    (head_pop),
        .rd_valid (head_valid),
        .rd_data  (head)
    );

    sqt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

endmodule

FILE: dv/tb_shell_quote_tokenizer.sv
// Testbench for the shell quote tokenizer: queued stimulus, scoreboard and final check.
`timescale 1ns / 1ps

module tb_shell_quote_tokenizer;

    import sqt_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int RAND_ITEMS  = 145;
    localparam int CYCLE_LIMIT = 50000;
    localparam int QUIET_LO    = 90;
    localparam int QUIET_HI    = 140;
    localparam int DRAIN_WAIT  = 20;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    push  = 1'b0;
    logic    pop   = 1'b0;
    item_t   item  = '0;
    logic    full;
    logic    empty;
    result_t result;

    // Characters waiting to be driven and results the tokenizer still owes.
    item_t       char_q[$];
    result_t     word_q[$];

    // Predicted tokenizer state.
    quote_mode_t qmode    = QM_PLAIN;
    logic        esc_pend = 1'b0;
    logic        word_on  = 1'b0;

    logic        in_fire   = 1'b0;
    int          taken_cnt = 0;
    int          cyc_cnt   = 0;
    int          err_cnt   = 0;
    logic        quiet;

    shell_quote_tokenizer u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial
    begin
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    assign quiet = (taken_cnt >= QUIET_LO) && (taken_cnt < QUIET_HI);

    function automatic logic is_blank(input logic [7:0] c);
        return (c >= 8'h09 && c <= 8'h0D) || c == 8'h20 || c == 8'h85 || c == 8'hA0;
    endfunction

    function automatic logic dq_escapes(input logic [7:0] c);
        return c == CH_DQUOTE || c == CH_BACKSLASH || c == CH_DOLLAR || c == CH_BACKTICK;
    endfunction

    // Advance the predicted state by one character and queue the results it produces.
    task automatic tokenize_char(input item_t it);
        result_t    out [3];
        int         n;
        logic [7:0] c;
        logic       eot;
        n   = 0;
        c   = it.in_char;
        eot = it.end_of_text;
        case (qmode)
            QM_SINGLE:
            begin
                if (c == CH_SQUOTE)
                    qmode = QM_PLAIN;
                else
                begin
                    out[n] = {KIND_CHAR, c, 1'b0};
                    n++;
                end
            end
            QM_DOUBLE:
            begin
                if (esc_pend)
                begin
                    esc_pend = 1'b0;
                    // keep the backslash unless it escapes this character
                    if (!dq_escapes(c))
                    begin
                        out[n] = {KIND_CHAR, CH_BACKSLASH, 1'b0};
                        n++;
                    end
                    out[n] = {KIND_CHAR, c, 1'b0};
                    n++;
                end
                else if (c == CH_BACKSLASH)
                begin
                    if (eot)
                    begin
                        out[n] = {KIND_CHAR, c, 1'b0};
                        n++;
                    end
                    else
                        esc_pend = 1'b1;
                end
                else if (c == CH_DQUOTE)
                    qmode = QM_PLAIN;
                else
                begin
                    out[n] = {KIND_CHAR, c, 1'b0};
                    n++;
                end
            end
            default:
            begin
                if (esc_pend)
                begin
                    esc_pend = 1'b0;
                    word_on  = 1'b1;
                    out[n]   = {KIND_CHAR, c, 1'b0};
                    n++;
                end
                else if (c == CH_SQUOTE)
                begin
                    qmode   = QM_SINGLE;
                    word_on = 1'b1;
                end
                else if (c == CH_DQUOTE)
                begin
                    qmode   = QM_DOUBLE;
                    word_on = 1'b1;
                end
                else if (c == CH_BACKSLASH)
                begin
                    word_on = 1'b1;
                    if (eot)
                    begin
                        out[n] = {KIND_CHAR, c, 1'b0};
                        n++;
                    end
                    else
                        esc_pend = 1'b1;
                end
                else if (is_blank(c))
                begin
                    if (word_on)
                    begin
                        out[n]  = {KIND_WORD_END, 8'h00, 1'b0};
                        n++;
                        word_on = 1'b0;
                    end
                end
                else
                begin
                    word_on = 1'b1;
                    out[n]  = {KIND_CHAR, c, 1'b0};
                    n++;
                end
            end
        endcase
        // close any open word and clear all state at end of text
        if (eot)
        begin
            if (word_on)
            begin
                out[n] = {KIND_WORD_END, 8'h00, 1'b0};
                n++;
            end
            qmode    = QM_PLAIN;
            esc_pend = 1'b0;
            word_on  = 1'b0;
        end
        if (n > 0)
            out[n-1].run_last = 1'b1;
        for (int i = 0; i < n; i++)
            word_q.push_back(out[i]);
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (word_q.size() == 0)
        begin
            $display("%0t: unexpected result: expected none, actual kind=%0d char=%02h last=%0d",
                     $time, got.result_kind, got.word_char, got.run_last);
            err_cnt++;
        end
        else
        begin
            want = word_q.pop_front();
            if (got.result_kind !== want.result_kind)
            begin
                $display("%0t: result_kind mismatch: expected %0d, actual %0d",
                         $time, want.result_kind, got.result_kind);
                err_cnt++;
            end
            if (got.word_char !== want.word_char)
            begin
                $display("%0t: word_char mismatch: expected %02h, actual %02h",
                         $time, want.word_char, got.word_char);
                err_cnt++;
            end
            if (got.run_last !== want.run_last)
            begin
                $display("%0t: run_last mismatch: expected %0d, actual %0d",
                         $time, want.run_last, got.run_last);
                err_cnt++;
            end
        end
    endtask

    // Sample both transfers at the rising edge.
    always @(posedge clk)
    begin
        cyc_cnt <= cyc_cnt + 1;
        in_fire <= rst_n && push && !full;
        if (rst_n && push && !full)
        begin
            tokenize_char(item);
            taken_cnt <= taken_cnt + 1;
        end
        if (rst_n && pop && !empty)
            check_result(result);
    end

    // Drive at the falling edge; drop the head of the queue once it transferred.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_fire)
                void'(char_q.pop_front());
            if (char_q.size() > 0 && (quiet || $urandom_range(0, 99) >= 25))
            begin
                push <= 1'b1;
                item <= char_q[0];
            end
            else
                push <= 1'b0;
            pop <= quiet || $urandom_range(0, 99) >= 25;
        end
    end

    task automatic add_char(input logic [7:0] c, input logic eot);
        item_t it;
        it.in_char     = c;
        it.end_of_text = eot;
        char_q.push_back(it);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 8'($urandom_range(0, 255));
        else if (r < 55)
        begin
            case ($urandom_range(0, 3))
                0:       return 8'h20;
                1:       return 8'($urandom_range(9, 13));
                2:       return 8'h85;
                default: return 8'hA0;
            endcase
        end
        else if (r < 67)
            return CH_SQUOTE;
        else if (r < 79)
            return CH_DQUOTE;
        else if (r < 89)
            return CH_BACKSLASH;
        else if (r < 95)
            return ($urandom_range(0, 1) == 0) ? CH_DOLLAR : CH_BACKTICK;
        else
            return 8'($urandom_range(8'h61, 8'h7A));
    endfunction

    task automatic wait_drained();
        while (char_q.size() > 0 || word_q.size() > 0)
            @(negedge clk);
    endtask

    initial
    begin
        int rand_cnt;
        int len;

        // Plain words split by a space.
        add_text("ab c");
        // Empty quoted pair.
        add_text("''");
        // Double quotes with an escaped dollar and a kept backslash.
        add_text("\"\\$\\q\"");
        // Trailing backslash on its own and inside double quotes.
        add_text("\\");
        add_text("\"\\");
        // Unclosed single quote.
        add_text("'a");
        // Extreme bytes and the high blanks.
        add_char(8'hFF, 1'b0);
        add_char(8'h85, 1'b0);
        add_char(8'h00, 1'b0);
        add_char(8'hA0, 1'b0);
        add_char(8'h09, 1'b0);
        add_char(8'h0D, 1'b1);
        // Escaped blank outside quotes.
        add_text("\\ ");

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Queue the random characters only once the directed words are all out.
        wait_drained();

        rand_cnt = 0;
        while (rand_cnt < RAND_ITEMS)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                    add_char(pick_char(), i == len - 1);
            end
            else
            begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    add_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
            rand_cnt += len;
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);

        if (err_cnt == 0)
            $display("shell_quote_tokenizer verification clean");
        else
            $display("shell_quote_tokenizer verification failed");
        $finish;
    end

    initial
    begin
        while (cyc_cnt < CYCLE_LIMIT)
            @(posedge clk);
        $display("%0t: timeout after %0d cycles", $time, cyc_cnt);
        $display("shell_quote_tokenizer verification failed");
        $finish;
    end

endmodule

FILE: sim.f
design/sqt_pkg.sv
design/sqt_front.sv
design/sqt_queue.sv
design/sqt_back.sv
design/shell_quote_tokenizer.sv
dv/tb_shell_quote_tokenizer.sv
